FILE: hw/rtl/ectc_pkg.sv
// Shared constants and calendar tables for the epoch-to-calendar converter.
package ectc_pkg;

    localparam int SECS_PER_DAY     = 86400;
    localparam int DAYS_PER_QUAD    = 1461;
    localparam int SECS_PER_HOUR    = 3600;
    localparam int SECS_PER_MIN     = 60;
    localparam int US_PER_HUNDREDTH = 10000;

    localparam int EPOCH_CHIP_YEAR_DEF = 2;

    localparam int SEC_W  = 31;
    localparam int US_W   = 20;
    localparam int DAY_W  = 15;
    localparam int SOD_W  = 17;
    localparam int DOY_W  = 9;
    localparam int YEAR_W = 7;

    function automatic logic [10:0] pre_days(input logic [1:0] y0);
        logic [10:0] d;
        case (y0)
            2'd0:    d = 11'd0;
            2'd1:    d = 11'd366;
            2'd2:    d = 11'd731;
            2'd3:    d = 11'd1096;
            default: d = 11'd0;
        endcase
        return d;
    endfunction

    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m, input logic leap);
        logic [DOY_W-1:0] d;
        logic [DOY_W-1:0] adj;
        adj = (leap && m >= 4'd3) ? 9'd1 : 9'd0;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d + adj;
    endfunction

endpackage

FILE: hw/rtl/ectc_cdiv.sv
// Pipelined restoring divider by a constant, STEPS quotient bits per stage.
module ectc_cdiv #(
    parameter int DW      = 31,
    parameter int QW      = 15,
    parameter int DIVISOR = 86400,
    parameter int STEPS   = 3,
    parameter int SW      = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_num,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_rem,
    output logic [SW-1:0] out_side
);
    import ectc_pkg::*;

    localparam int NS = (QW + STEPS - 1) / STEPS;
    localparam int EW = DW + QW;
    localparam logic [EW-1:0] DV = EW'(DIVISOR);

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    logic [DW-1:0] rem_reg  [NS];
    logic [QW-1:0] quo_reg  [NS];
    logic [SW-1:0] side_reg [NS];

    assign rdy[NS] = out_ready;

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            logic          v_in;
            logic [DW-1:0] r_in;
            logic [QW-1:0] q_in;
            logic [SW-1:0] sd_in;
            logic [DW-1:0] r_next;
            logic [QW-1:0] q_next;

            if (s == 0) begin : g_first
                assign v_in  = in_valid;
                assign r_in  = in_num;
                assign q_in  = '0;
                assign sd_in = in_side;
            end else begin : g_rest
                assign v_in  = v_reg[s-1];
                assign r_in  = rem_reg[s-1];
                assign q_in  = quo_reg[s-1];
                assign sd_in = side_reg[s-1];
            end

            assign rdy[s] = !v_reg[s] || rdy[s+1];

            always_comb
            begin
                logic [EW-1:0] r;
                logic [EW-1:0] t;
                int            b;
                r      = EW'(r_in);
                q_next = q_in;
                for (int j = 0; j < STEPS; j++)
                begin
                    b = QW - 1 - s * STEPS - j;
                    if (b >= 0)
                    begin
                        t = DV << b;
                        if (r >= t)
                        begin
                            r      = r - t;
                            q_next = q_next | (QW'(1) << b);
                        end
                    end
                end
                r_next = r[DW-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (rdy[s])
                begin
                    v_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s] && v_in)
                begin
                    rem_reg[s]  <= r_next;
                    quo_reg[s]  <= q_next;
                    side_reg[s] <= sd_in;
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_rem   = rem_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

FILE: hw/rtl/ectc_finish.sv
// Year, month, time-of-day and hundredths stages after the day split.
module ectc_finish #(
    parameter int EPOCH_CHIP_YEAR = ectc_pkg::EPOCH_CHIP_YEAR_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ectc_pkg::DAY_W-1:0]  days,
    input  logic [ectc_pkg::SOD_W-1:0]  sod,
    input  logic [ectc_pkg::US_W-1:0]   us,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [6:0]                  chip_year,
    output logic [3:0]                  month,
    output logic [4:0]                  day_of_month,
    output logic [4:0]                  hour,
    output logic [5:0]                  minute,
    output logic [5:0]                  second,
    output logic [6:0]                  hundredths,
    output logic [2:0]                  weekday
);
    import ectc_pkg::*;

    localparam logic [10:0] PreDays = pre_days(2'(EPOCH_CHIP_YEAR));

    logic             a_valid_reg;
    logic [6:0]       a_year_reg;
    logic             a_leap_reg;
    logic [DOY_W-1:0] a_doy_reg;
    logic [4:0]       a_hour_reg;
    logic [11:0]      a_hrem_reg;
    logic [6:0]       a_hund_reg;

    logic             b_valid_reg;
    logic [6:0]       b_year_reg;
    logic [3:0]       b_month_reg;
    logic [4:0]       b_dom_reg;
    logic [4:0]       b_hour_reg;
    logic [5:0]       b_min_reg;
    logic [5:0]       b_sec_reg;
    logic [6:0]       b_hund_reg;
    logic [2:0]       b_wday_reg;

    logic             b_ready;

    logic [6:0]       a_year_next;
    logic             a_leap_next;
    logic [DOY_W-1:0] a_doy_next;
    logic [4:0]       a_hour_next;
    logic [11:0]      a_hrem_next;
    logic [6:0]       a_hund_next;

    logic [3:0]       b_month_next;
    logic [4:0]       b_dom_next;
    logic [5:0]       b_min_next;
    logic [5:0]       b_sec_next;
    logic [2:0]       b_wday_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || b_ready;

    always_comb
    begin
        logic [15:0]  d;
        logic [4:0]   quad;
        logic [1:0]   yq;
        logic [16:0]  s;
        logic [19:0]  u;
        d    = 16'(days) + 16'(PreDays);
        quad = '0;
        for (int b = 4; b >= 0; b--)
        begin
            if (d >= (16'(DAYS_PER_QUAD) << b))
            begin
                d       = d - (16'(DAYS_PER_QUAD) << b);
                quad[b] = 1'b1;
            end
        end
        if (d < 16'd366)
        begin
            yq = 2'd0;
            a_doy_next = d[DOY_W-1:0];
        end
        else if (d < 16'd731)
        begin
            yq = 2'd1;
            a_doy_next = 9'(d - 16'd366);
        end
        else if (d < 16'd1096)
        begin
            yq = 2'd2;
            a_doy_next = 9'(d - 16'd731);
        end
        else
        begin
            yq = 2'd3;
            a_doy_next = 9'(d - 16'd1096);
        end
        a_year_next = {quad, yq};
        a_leap_next = (yq == 2'd0);

        s           = sod;
        a_hour_next = '0;
        for (int b = 4; b >= 0; b--)
        begin
            if (s >= (17'(SECS_PER_HOUR) << b))
            begin
                s              = s - (17'(SECS_PER_HOUR) << b);
                a_hour_next[b] = 1'b1;
            end
        end
        a_hrem_next = s[11:0];

        u           = us;
        a_hund_next = '0;
        for (int b = 6; b >= 0; b--)
        begin
            if (u >= (20'(US_PER_HUNDREDTH) << b))
            begin
                u              = u - (20'(US_PER_HUNDREDTH) << b);
                a_hund_next[b] = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [11:0] r;
        logic [4:0]  w;
        b_month_next = 4'd1;
        for (int m = 2; m <= 12; m++)
        begin
            if (a_doy_reg >= month_start(4'(m), a_leap_reg))
            begin
                b_month_next = 4'(m);
            end
        end
        b_dom_next = 5'(a_doy_reg - month_start(b_month_next, a_leap_reg) + 9'd1);

        r          = a_hrem_reg;
        b_min_next = '0;
        for (int b = 5; b >= 0; b--)
        begin
            if (r >= (12'(SECS_PER_MIN) << b))
            begin
                r             = r - (12'(SECS_PER_MIN) << b);
                b_min_next[b] = 1'b1;
            end
        end
        b_sec_next = r[5:0];

        w = b_dom_next;
        if (w >= 5'd28)
        begin
            w = w - 5'd28;
        end
        if (w >= 5'd14)
        begin
            w = w - 5'd14;
        end
        if (w >= 5'd7)
        begin
            w = w - 5'd7;
        end
        b_wday_next = w[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_year_reg <= a_year_next;
            a_leap_reg <= a_leap_next;
            a_doy_reg  <= a_doy_next;
            a_hour_reg <= a_hour_next;
            a_hrem_reg <= a_hrem_next;
            a_hund_reg <= a_hund_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_year_reg  <= a_year_reg;
            b_month_reg <= b_month_next;
            b_dom_reg   <= b_dom_next;
            b_hour_reg  <= a_hour_reg;
            b_min_reg   <= b_min_next;
            b_sec_reg   <= b_sec_next;
            b_hund_reg  <= a_hund_reg;
            b_wday_reg  <= b_wday_next;
        end
    end

    assign out_valid    = b_valid_reg;
    assign chip_year    = b_year_reg;
    assign month        = b_month_reg;
    assign day_of_month = b_dom_reg;
    assign hour         = b_hour_reg;
    assign minute       = b_min_reg;
    assign second       = b_sec_reg;
    assign hundredths   = b_hund_reg;
    assign weekday      = b_wday_reg;

`ifndef SYNTHESIS
    a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_doy_reg < 9'd365 || (a_leap_reg && a_doy_reg == 9'd365)))
        else $error("day of year past year length");
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_hour_reg < 5'd24 && a_hrem_reg < 12'd3600))
        else $error("time of day split out of range");
    b_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1))
        else $error("month or day out of range");
    b_wday_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (weekday < 3'd7 && minute < 6'd60 && second < 6'd60))
        else $error("weekday or minute/second out of range");
`endif

endmodule

FILE: hw/rtl/epoch_seconds_to_calendar_top.sv
// Top level of the epoch-seconds to calendar-field converter.
// One beat of seconds and microseconds yields one beat of chip calendar fields:
// five divider stages split the seconds into whole days and seconds of the day
// (three quotient bits per stage), then one stage resolves the four-year cycle,
// year, hour and hundredths and a last stage resolves month, day, minute, second
// and weekday. A new beat is taken every cycle; a stall at the output holds each
// stage in place.
module epoch_seconds_to_calendar_top #(
    parameter int EPOCH_CHIP_YEAR = ectc_pkg::EPOCH_CHIP_YEAR_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ectc_pkg::SEC_W-1:0]  unix_seconds,
    input  logic [ectc_pkg::US_W-1:0]   microseconds,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [6:0]                  chip_year,
    output logic [3:0]                  month,
    output logic [4:0]                  day_of_month,
    output logic [4:0]                  hour,
    output logic [5:0]                  minute,
    output logic [5:0]                  second,
    output logic [6:0]                  hundredths,
    output logic [2:0]                  weekday
);
    import ectc_pkg::*;

    logic             dv_valid;
    logic             dv_ready;
    logic [DAY_W-1:0] dv_days;
    logic [SEC_W-1:0] dv_rem;
    logic [US_W-1:0]  dv_us;

    ectc_cdiv #(
        .DW      (SEC_W),
        .QW      (DAY_W),
        .DIVISOR (SECS_PER_DAY),
        .STEPS   (3),
        .SW      (US_W)
    ) u_day_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_num    (unix_seconds),
        .in_side   (microseconds),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_quo   (dv_days),
        .out_rem   (dv_rem),
        .out_side  (dv_us)
    );

    ectc_finish #(
        .EPOCH_CHIP_YEAR (EPOCH_CHIP_YEAR)
    ) u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (dv_valid),
        .in_ready     (dv_ready),
        .days         (dv_days),
        .sod          (dv_rem[SOD_W-1:0]),
        .us           (dv_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chip_year    (chip_year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .hundredths   (hundredths),
        .weekday      (weekday)
    );

endmodule

FILE: tb/epoch_seconds_to_calendar_top_tb.sv
// Testbench for the epoch-seconds to calendar converter: directed and random beats checked in order.
module epoch_seconds_to_calendar_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EPOCH_YEAR = ectc_pkg::EPOCH_CHIP_YEAR_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [6:0] chip_year;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] hundredths;
        logic [2:0] weekday;
    } calendar_t;

    class calendar_scoreboard;
        calendar_t pending[$];
        int errors;
        int checked;

        function automatic int unsigned days_in_month(int unsigned mon, int unsigned yr);
            int unsigned lens[12];
            lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            if (mon == 2 && (yr % 4) == 0)
                return 29;
            return lens[mon - 1];
        endfunction

        function void note_input(logic [30:0] secs, logic [19:0] usec);
            int unsigned t;
            int unsigned yr;
            int unsigned mon;
            int unsigned ylen;
            int unsigned day;
            int unsigned hund;
            calendar_t c;
            t = 32'(secs);
            yr = EPOCH_YEAR;
            mon = 1;
            ylen = ((yr % 4) == 0 ? 366 : 365) * 86400;
            while (t >= ylen)
            begin
                t -= ylen;
                yr++;
                ylen = ((yr % 4) == 0 ? 366 : 365) * 86400;
            end
            while (mon < 12 && t >= days_in_month(mon, yr) * 86400)
            begin
                t -= days_in_month(mon, yr) * 86400;
                mon++;
            end
            day = t / 86400 + 1;
            hund = 32'(usec) / 10000;
            c.chip_year = yr[6:0];
            c.month = mon[3:0];
            c.day_of_month = day[4:0];
            c.hour = 5'((t / 3600) % 24);
            c.minute = 6'((t / 60) % 60);
            c.second = 6'(t % 60);
            c.hundredths = hund[6:0];
            c.weekday = 3'(day % 7);
            pending.push_back(c);
        endfunction

        function void check_result(calendar_t got);
            calendar_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.chip_year !== e.chip_year)
            begin
                $error("chip_year expected %0d actual %0d", e.chip_year, got.chip_year);
                errors++;
            end
            if (got.month !== e.month)
            begin
                $error("month expected %0d actual %0d", e.month, got.month);
                errors++;
            end
            if (got.day_of_month !== e.day_of_month)
            begin
                $error("day_of_month expected %0d actual %0d", e.day_of_month, got.day_of_month);
                errors++;
            end
            if (got.hour !== e.hour)
            begin
                $error("hour expected %0d actual %0d", e.hour, got.hour);
                errors++;
            end
            if (got.minute !== e.minute)
            begin
                $error("minute expected %0d actual %0d", e.minute, got.minute);
                errors++;
            end
            if (got.second !== e.second)
            begin
                $error("second expected %0d actual %0d", e.second, got.second);
                errors++;
            end
            if (got.hundredths !== e.hundredths)
            begin
                $error("hundredths expected %0d actual %0d", e.hundredths, got.hundredths);
                errors++;
            end
            if (got.weekday !== e.weekday)
            begin
                $error("weekday expected %0d actual %0d", e.weekday, got.weekday);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [30:0] unix_seconds = '0;
    logic [19:0] microseconds = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [6:0] chip_year;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] hundredths;
    logic [2:0] weekday;

    calendar_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int beats_sent = 0;

    epoch_seconds_to_calendar_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .unix_seconds(unix_seconds), .microseconds(microseconds),
        .out_valid(out_valid), .out_ready(out_ready),
        .chip_year(chip_year), .month(month), .day_of_month(day_of_month),
        .hour(hour), .minute(minute), .second(second),
        .hundredths(hundredths), .weekday(weekday)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result({chip_year, month, day_of_month, hour, minute, second,
                                 hundredths, weekday});
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles with no beat", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_beat(input logic [30:0] secs, input logic [19:0] usec);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        unix_seconds <= secs;
        microseconds <= usec;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(secs, usec);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [30:0] year_start(int unsigned years);
        int unsigned s;
        s = 0;
        for (int unsigned y = 0; y < years; y++)
            s += (((EPOCH_YEAR + y) % 4) == 0 ? 366 : 365) * 86400;
        return 31'(s);
    endfunction

    function automatic logic [30:0] random_seconds();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'(year_start($urandom_range(60)) + $urandom_range(2) - 1);
            2: return 31'($urandom_range(4 * 366 * 86400));
            default: return 31'(year_start($urandom_range(30)) + $urandom_range(400) * 86400
                                - $urandom_range(1));
        endcase
    endfunction

    initial
    begin
        logic [30:0] s;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(31'd0, 20'd0);
        send_beat(31'h7FFFFFFF, 20'hFFFFF);
        send_beat(31'd86399, 20'd999999);
        send_beat(31'd86400, 20'd1000000);
        send_beat(31'd9999, 20'd10000);
        send_beat(year_start(1) - 31'd1, 20'd9999);
        send_beat(year_start(1), 20'd123456);
        send_beat(year_start(2) - 31'd1, 20'd0);
        send_beat(year_start(2), 20'd0);
        send_beat(31'(year_start(2) + 59 * 86400 - 1), 20'd0);
        send_beat(31'(year_start(2) + 59 * 86400), 20'd0);
        send_beat(31'(year_start(2) + 60 * 86400), 20'd0);
        send_beat(year_start(3) - 31'd1, 20'd0);
        send_beat(31'(31 * 86400 - 1), 20'd0);
        send_beat(31'(31 * 86400), 20'd0);
        send_beat(31'(334 * 86400), 20'd0);
        send_beat(31'h2AAAAAAA, 20'h55555);
        send_beat(31'h55555555, 20'hAAAAA);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 53 : 27) : 0;
            recv_stall_pct = (phase == 2) ? 53 : (phase == 3 ? 27 : 0);
            for (int i = 0; i < 333; i++)
            begin
                s = random_seconds();
                send_beat(s, 20'($urandom_range(9) == 0 ? $urandom_range(1048575)
                                                        : $urandom_range(999999)));
                if (i == 150)
                    drain();
            end
        end

        drain();
        repeat (50) @(posedge clk);
        $display("sent %0d beats over four idle/stall phases, checked %0d results",
                 beats_sent, sb.checked);
        $display("covered year, month and day boundaries plus out-of-range microseconds");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
